// File: design/hall_signals_to_conductivity_tensor_macros.svh
// Assertion macros shared by the checker of the conductivity tensor block.
`ifndef HALL_SIGNALS_TO_CONDUCTIVITY_TENSOR_MACROS_SVH
`define HALL_SIGNALS_TO_CONDUCTIVITY_TENSOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and switched off during reset.
`define HSTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hstc checker: property failed");

// Next-cycle implication, sampled on clk_i and switched off during reset.
`define HSTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hstc checker: property failed");

`endif

// File: design/hstc_pkg.sv
// Shared types, constants and binary32 helper functions of the tensor block.
`default_nettype none
package hstc_pkg;

  // Control group handed from an arithmetic front end to the rounder.
  typedef struct packed {
    logic        special;
    logic [31:0] bits;
    logic        sign;
  } rnd_ctl_t;

  localparam logic [31:0] QNAN_POS    = 32'h7FC0_0000;
  localparam logic [31:0] QNAN_NEG    = 32'hFFC0_0000;
  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  // Smallest binary32 magnitude that is not below 1e-11.
  localparam logic [30:0] SMALL_LIMIT = 31'h2D2F_EC00;

  localparam int unsigned LAT_MUL = 4;
  localparam int unsigned LAT_DIV = 9;
  localparam int unsigned LAT_ADD = 5;

  localparam int unsigned IN_W     = 64;
  localparam int unsigned OUT_W    = 128;
  localparam int unsigned CFG_IDXW = 2;

  localparam logic [CFG_IDXW-1:0] REG_RATIO   = 2'd0;
  localparam logic [CFG_IDXW-1:0] REG_THICK   = 2'd1;
  localparam logic [CFG_IDXW-1:0] REG_CURRENT = 2'd2;

  function automatic logic is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return !(|x[30:0]);
  endfunction

  function automatic logic [31:0] quiet(input logic [31:0] x);
    return x | QUIET_BIT;
  endfunction

  // Significand with the hidden bit, zero for subnormals.
  function automatic logic [23:0] sig(input logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  // Effective biased exponent: subnormals share the exponent of the smallest normal.
  function automatic logic [7:0] bexp(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
  endfunction

endpackage
`default_nettype wire

// File: design/hstc_round.sv
// Three-stage normalise and round-to-nearest-even unit producing binary32.
`default_nettype none
module hstc_round #(
  parameter int unsigned W  = 28,
  parameter int unsigned EW = 10
) (
  input  wire                     clk_i,
  input  wire                     en_i,
  input  wire hstc_pkg::rnd_ctl_t ctl_i,
  input  wire  [W-1:0]            mag_i,
  input  wire  signed [EW-1:0]    exp_i,
  output logic [31:0]             res_o
);
  localparam int unsigned LZW = $clog2(W + 1);
  localparam logic signed [EW-1:0] WIDTH_S = EW'(W);
  localparam logic signed [EW-1:0] EXP_MAX = EW'(255);
  localparam logic signed [EW-1:0] EXP_MIN = EW'(1);

  hstc_pkg::rnd_ctl_t ctl1_q, ctl2_q;
  logic [W-1:0]         mag1_q, m2_q, m2_d, norm;
  logic signed [EW-1:0] exp1_q, be, sh;
  logic [LZW-1:0]       lz_d, lz1_q;
  logic                 zero1_q, zero2_q, st2_q, st2_d, ovf2_q;
  logic [7:0]           ef2_q, ef2_d;
  logic [23:0]          top;
  logic                 grd, stk, inc;
  logic [30:0]          pack, sum;
  logic [31:0]          res_d, res_q;

  // Leading-zero count; the highest set bit wins.
  always_comb begin
    lz_d = LZW'(W);
    for (int i = 0; i < W; i++) begin
      if (mag_i[i]) lz_d = LZW'(W - 1 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl1_q  <= ctl_i;
      mag1_q  <= mag_i;
      exp1_q  <= exp_i;
      lz1_q   <= lz_d;
      zero1_q <= !(|mag_i);
    end
  end

  // Normalise, then denormalise when the exponent falls below the normal range.
  always_comb begin
    norm  = mag1_q << lz1_q;
    be    = exp1_q - EW'(lz1_q);
    sh    = EXP_MIN - be;
    m2_d  = norm;
    st2_d = 1'b0;
    ef2_d = be[7:0];
    if (be < EXP_MIN) begin
      ef2_d = 8'd0;
      if (sh >= WIDTH_S) begin
        m2_d  = '0;
        st2_d = |norm;
      end else begin
        m2_d  = norm >> sh;
        st2_d = |(norm & ~({W{1'b1}} << sh));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl2_q  <= ctl1_q;
      zero2_q <= zero1_q;
      m2_q    <= m2_d;
      st2_q   <= st2_d;
      ef2_q   <= ef2_d;
      ovf2_q  <= (be >= EXP_MAX);
    end
  end

  // Round; a carry out of the fraction steps the exponent up, up to infinity.
  always_comb begin
    top  = m2_q[W-1 -: 24];
    grd  = m2_q[W-25];
    stk  = st2_q | (|m2_q[W-26:0]);
    inc  = grd & (stk | top[0]);
    pack = {ef2_q, top[22:0]};
    sum  = pack + 31'(inc);
    if (ctl2_q.special)  res_d = ctl2_q.bits;
    else if (zero2_q)    res_d = {ctl2_q.sign, 31'd0};
    else if (ovf2_q)     res_d = {ctl2_q.sign, 8'hFF, 23'd0};
    else                 res_d = {ctl2_q.sign, sum};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

// File: design/hstc_fmul.sv
// Pipelined binary32 multiplier: product stage followed by the rounder.
`default_nettype none
module hstc_fmul (
  input  wire         clk_i,
  input  wire         en_i,
  input  wire  [31:0] a_i,
  input  wire  [31:0] b_i,
  output logic [31:0] res_o
);
  localparam int unsigned EW = 12;

  hstc_pkg::rnd_ctl_t   ctl_d, ctl_q;
  logic [47:0]          prod_q;
  logic signed [EW-1:0] xe_d, xe_q;
  logic                 sgn;

  always_comb begin
    sgn           = a_i[31] ^ b_i[31];
    ctl_d.sign    = sgn;
    ctl_d.special = 1'b1;
    ctl_d.bits    = {sgn, 31'd0};
    if (hstc_pkg::is_nan(a_i))      ctl_d.bits = hstc_pkg::quiet(a_i);
    else if (hstc_pkg::is_nan(b_i)) ctl_d.bits = hstc_pkg::quiet(b_i);
    else if ((hstc_pkg::is_inf(a_i) && hstc_pkg::is_zero(b_i)) ||
             (hstc_pkg::is_zero(a_i) && hstc_pkg::is_inf(b_i)))
      ctl_d.bits = hstc_pkg::QNAN_NEG;
    else if (hstc_pkg::is_inf(a_i) || hstc_pkg::is_inf(b_i))
      ctl_d.bits = {sgn, 8'hFF, 23'd0};
    else if (hstc_pkg::is_zero(a_i) || hstc_pkg::is_zero(b_i))
      ctl_d.bits = {sgn, 31'd0};
    else
      ctl_d.special = 1'b0;
    xe_d = EW'(hstc_pkg::bexp(a_i)) + EW'(hstc_pkg::bexp(b_i)) - EW'(126);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_d;
      prod_q <= hstc_pkg::sig(a_i) * hstc_pkg::sig(b_i);
      xe_q   <= xe_d;
    end
  end

  hstc_round #(.W(48), .EW(EW)) u_round (
    .clk_i (clk_i),
    .en_i  (en_i),
    .ctl_i (ctl_q),
    .mag_i (prod_q),
    .exp_i (xe_q),
    .res_o (res_o)
  );
endmodule
`default_nettype wire

// File: design/hstc_fdiv.sv
// Pipelined binary32 divider: restoring quotient stages followed by the rounder.
`default_nettype none
module hstc_fdiv (
  input  wire         clk_i,
  input  wire         en_i,
  input  wire  [31:0] a_i,
  input  wire  [31:0] b_i,
  output logic [31:0] res_o
);
  localparam int unsigned EW     = 10;
  localparam int unsigned QW     = 27;
  localparam int unsigned STAGES = 4;
  localparam int unsigned SPS    = 7;

  hstc_pkg::rnd_ctl_t ctl_d, ctl_u_q;
  logic [23:0] a_u_q, b_u_q;
  logic [7:0]  ea_u_q, eb_u_q;
  logic        sgn;

  always_comb begin
    sgn           = a_i[31] ^ b_i[31];
    ctl_d.sign    = sgn;
    ctl_d.special = 1'b1;
    ctl_d.bits    = {sgn, 31'd0};
    if (hstc_pkg::is_zero(b_i)) begin
      if (hstc_pkg::is_nan(a_i) || hstc_pkg::is_zero(a_i)) ctl_d.bits = hstc_pkg::QNAN_POS;
      else                                                  ctl_d.bits = {sgn, 8'hFF, 23'd0};
    end else if (hstc_pkg::is_nan(a_i)) ctl_d.bits = hstc_pkg::quiet(a_i);
    else if (hstc_pkg::is_nan(b_i))     ctl_d.bits = hstc_pkg::quiet(b_i);
    else if (hstc_pkg::is_inf(a_i) && hstc_pkg::is_inf(b_i)) ctl_d.bits = hstc_pkg::QNAN_NEG;
    else if (hstc_pkg::is_inf(a_i))     ctl_d.bits = {sgn, 8'hFF, 23'd0};
    else if (hstc_pkg::is_inf(b_i) || hstc_pkg::is_zero(a_i)) ctl_d.bits = {sgn, 31'd0};
    else                                ctl_d.special = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_u_q <= ctl_d;
      a_u_q   <= hstc_pkg::sig(a_i);
      b_u_q   <= hstc_pkg::sig(b_i);
      ea_u_q  <= hstc_pkg::bexp(a_i);
      eb_u_q  <= hstc_pkg::bexp(b_i);
    end
  end

  // Normalise subnormal significands so both carry their leading one at bit 23.
  logic [4:0]           lza, lzb;
  logic signed [EW-1:0] ean, ebn;

  always_comb begin
    lza = 5'd0;
    lzb = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (a_u_q[i]) lza = 5'(23 - i);
      if (b_u_q[i]) lzb = 5'(23 - i);
    end
    ean = EW'(ea_u_q) - EW'(lza);
    ebn = EW'(eb_u_q) - EW'(lzb);
  end

  hstc_pkg::rnd_ctl_t   ctl_s_q [STAGES+1];
  logic [25:0]          r_s_q   [STAGES+1];
  logic [QW-1:0]        q_s_q   [STAGES+1];
  logic [23:0]          b_s_q   [STAGES+1];
  logic signed [EW-1:0] xe_s_q  [STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_s_q[0] <= ctl_u_q;
      r_s_q[0]   <= 26'(a_u_q << lza);
      q_s_q[0]   <= '0;
      b_s_q[0]   <= b_u_q << lzb;
      xe_s_q[0]  <= ean - ebn + EW'(127);
    end
  end

  // Each stage resolves up to SPS quotient bits, most significant first; the last stage resolves the remaining six.
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int HI = QW - 1 - SPS * k;
    logic [25:0]   r_d;
    logic [QW-1:0] q_d;

    always_comb begin
      r_d = r_s_q[k];
      q_d = q_s_q[k];
      for (int j = 0; j < SPS; j++) begin
        if (HI - j >= 0) begin
          if (r_d >= 26'(b_s_q[k])) begin
            r_d         = r_d - 26'(b_s_q[k]);
            q_d[HI - j] = 1'b1;
          end
          r_d = r_d << 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_s_q[k+1] <= ctl_s_q[k];
        r_s_q[k+1]   <= r_d;
        q_s_q[k+1]   <= q_d;
        b_s_q[k+1]   <= b_s_q[k];
        xe_s_q[k+1]  <= xe_s_q[k];
      end
    end
  end

  hstc_round #(.W(QW + 1), .EW(EW)) u_round (
    .clk_i (clk_i),
    .en_i  (en_i),
    .ctl_i (ctl_s_q[STAGES]),
    .mag_i ({q_s_q[STAGES], |r_s_q[STAGES]}),
    .exp_i (xe_s_q[STAGES]),
    .res_o (res_o)
  );
endmodule
`default_nettype wire

// File: design/hstc_fadd.sv
// Pipelined binary32 adder: align stage, add stage, then the rounder.
`default_nettype none
module hstc_fadd (
  input  wire         clk_i,
  input  wire         en_i,
  input  wire  [31:0] a_i,
  input  wire  [31:0] b_i,
  output logic [31:0] res_o
);
  localparam int unsigned EW = 10;

  hstc_pkg::rnd_ctl_t ctl_d, ctl1_q, ctl2_d, ctl2_q;
  logic [31:0] lg, sm;
  logic [7:0]  d;
  logic [26:0] ext, al_d, al1_q, big1_q;
  logic [7:0]  el1_q;
  logic        sub1_q, zs1_q;
  logic [27:0] m_d, m2_q;
  logic signed [EW-1:0] xe2_q;

  always_comb begin
    ctl_d.special = 1'b1;
    ctl_d.bits    = a_i;
    if (hstc_pkg::is_nan(a_i))      ctl_d.bits = hstc_pkg::quiet(a_i);
    else if (hstc_pkg::is_nan(b_i)) ctl_d.bits = hstc_pkg::quiet(b_i);
    else if (hstc_pkg::is_inf(a_i) && hstc_pkg::is_inf(b_i) && (a_i[31] != b_i[31]))
      ctl_d.bits = hstc_pkg::QNAN_NEG;
    else if (hstc_pkg::is_inf(a_i)) ctl_d.bits = a_i;
    else if (hstc_pkg::is_inf(b_i)) ctl_d.bits = b_i;
    else                            ctl_d.special = 1'b0;

    if (a_i[30:0] >= b_i[30:0]) begin
      lg = a_i;
      sm = b_i;
    end else begin
      lg = b_i;
      sm = a_i;
    end
    // The result takes the sign of the larger addend.
    ctl_d.sign = lg[31];
    d   = hstc_pkg::bexp(lg) - hstc_pkg::bexp(sm);
    ext = {hstc_pkg::sig(sm), 3'b000};
    if (d >= 8'd27) begin
      al_d = {26'd0, |ext};
    end else begin
      al_d    = ext >> d;
      al_d[0] = al_d[0] | (|(ext & ~({27{1'b1}} << d)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl1_q <= ctl_d;
      big1_q <= {hstc_pkg::sig(lg), 3'b000};
      al1_q  <= al_d;
      el1_q  <= hstc_pkg::bexp(lg);
      sub1_q <= a_i[31] ^ b_i[31];
      zs1_q  <= a_i[31] & b_i[31];
    end
  end

  // An exact zero sum is negative only when both addends are negative.
  always_comb begin
    if (sub1_q) m_d = {1'b0, big1_q} - {1'b0, al1_q};
    else        m_d = {1'b0, big1_q} + {1'b0, al1_q};
    ctl2_d      = ctl1_q;
    ctl2_d.sign = (m_d == 28'd0) ? zs1_q : ctl1_q.sign;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl2_q <= ctl2_d;
      m2_q   <= m_d;
      xe2_q  <= EW'(el1_q) + EW'(1);
    end
  end

  hstc_round #(.W(28), .EW(EW)) u_round (
    .clk_i (clk_i),
    .en_i  (en_i),
    .ctl_i (ctl2_q),
    .mag_i (m2_q),
    .exp_i (xe2_q),
    .res_o (res_o)
  );
endmodule
`default_nettype wire

// File: design/hall_signals_to_conductivity_tensor.sv
// Top level of the Hall-signal to conductivity-tensor inversion pipeline.
//
// Usage: each beat on the slave stream carries one binary32 sample pair, the
// longitudinal voltage in the low word and the Hall voltage in the high word.
// For every accepted beat exactly one beat leaves on the master stream with
// the effective conductivity, the Hall coefficient and the two tensor
// components in tdata and the small-signal flag in tuser.
// Geometry ratio, film thickness and drive current are written through the
// configuration channel, which is always ready; they must only change while
// no sample is in flight.
// An accepted input beat passes through the chain of divide, multiply and
// add units (the longest path is divide, multiply, divide, two multiplies,
// add, divide) and then the output register, leaving as the matching output
// beat. A new beat is taken every cycle while the pipeline is not frozen.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the one beat still leaving the pipeline; the pipeline then
// freezes and s_axis_tready falls until the skid register drains.
// Reset clears all valid flags and loads 1.0 into the three registers.
`default_nettype none
module hall_signals_to_conductivity_tensor (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // longitudinal_voltage [31:0], hall_voltage [63:32]
  input  wire  [hstc_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // effective_conductivity [31:0], hall_coefficient [63:32],
  // tensor_xx [95:64], tensor_xy [127:96]
  output logic [hstc_pkg::OUT_W-1:0]        m_axis_tdata,
  // small_signal [0]
  output logic [0:0]                        m_axis_tuser,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [hstc_pkg::CFG_IDXW-1:0]     cfg_index_i,
  input  wire  [31:0]                       cfg_data_i
);
  // Points in time, counted in cycles from acceptance, where values appear.
  localparam int unsigned T_M1  = hstc_pkg::LAT_DIV + hstc_pkg::LAT_MUL;
  localparam int unsigned T_S   = T_M1 + hstc_pkg::LAT_DIV;
  localparam int unsigned T_RH  = hstc_pkg::LAT_MUL + hstc_pkg::LAT_DIV;
  localparam int unsigned T_M3  = T_RH + hstc_pkg::LAT_MUL;
  localparam int unsigned T_S1  = T_S + hstc_pkg::LAT_MUL;
  localparam int unsigned T_DEN = T_S + 2 * hstc_pkg::LAT_MUL + hstc_pkg::LAT_ADD;
  localparam int unsigned T_OUT = T_DEN + hstc_pkg::LAT_DIV;

  // Configuration registers.
  logic [31:0] ratio_q, thick_q, cur_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= hstc_pkg::FP_ONE;
      thick_q <= hstc_pkg::FP_ONE;
      cur_q   <= hstc_pkg::FP_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hstc_pkg::REG_RATIO:   ratio_q <= cfg_data_i;
        hstc_pkg::REG_THICK:   thick_q <= cfg_data_i;
        hstc_pkg::REG_CURRENT: cur_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the skid register is full.
  logic skid_valid_q;
  logic en;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  logic [31:0] us, uy;
  logic        small_now;

  assign us        = s_axis_tdata[31:0];
  assign uy        = s_axis_tdata[63:32];
  // Magnitude below 1e-11; a NaN pattern compares above the limit.
  assign small_now = (us[30:0] < hstc_pkg::SMALL_LIMIT);

  // Arithmetic units.
  logic [31:0] d1_res, m1_res, d2_res, m2_res, rh, m3_res, m4_res, m5_res;
  logic [31:0] den, m6_res, m7_res, xx, xy, s_now;

  // Delay lines that keep operands aligned with the unit outputs.
  logic          v_q    [T_OUT];
  logic          sm_q   [T_OUT];
  logic [31:0]   us_q   [T_M1];
  logic [31:0]   rh_q   [T_OUT - T_RH];
  logic [31:0]   m3_q   [T_S - T_M3];
  logic [31:0]   s_q    [T_OUT - T_S];
  logic [31:0]   m7_q   [hstc_pkg::LAT_ADD];

  hstc_fdiv u_d1 (.clk_i(clk_i), .en_i(en), .a_i(ratio_q), .b_i(thick_q), .res_o(d1_res));
  hstc_fmul u_m1 (.clk_i(clk_i), .en_i(en), .a_i(d1_res), .b_i(cur_q), .res_o(m1_res));
  hstc_fdiv u_d2 (.clk_i(clk_i), .en_i(en), .a_i(m1_res), .b_i(us_q[T_M1-1]),
                  .res_o(d2_res));

  hstc_fmul u_m2 (.clk_i(clk_i), .en_i(en), .a_i(thick_q), .b_i(uy), .res_o(m2_res));
  hstc_fdiv u_d3 (.clk_i(clk_i), .en_i(en), .a_i(m2_res), .b_i(cur_q), .res_o(rh));

  // Conductivity is forced to positive zero for a small longitudinal signal.
  assign s_now = sm_q[T_S-1] ? 32'd0 : d2_res;

  hstc_fmul u_m3 (.clk_i(clk_i), .en_i(en), .a_i(rh), .b_i(rh), .res_o(m3_res));
  hstc_fmul u_m4 (.clk_i(clk_i), .en_i(en), .a_i(m3_q[T_S-T_M3-1]), .b_i(s_now),
                  .res_o(m4_res));
  hstc_fmul u_m5 (.clk_i(clk_i), .en_i(en), .a_i(m4_res), .b_i(s_q[T_S1-T_S-1]),
                  .res_o(m5_res));
  hstc_fadd u_a1 (.clk_i(clk_i), .en_i(en), .a_i(m5_res), .b_i(hstc_pkg::FP_ONE),
                  .res_o(den));

  hstc_fmul u_m6 (.clk_i(clk_i), .en_i(en), .a_i(s_now), .b_i(s_now), .res_o(m6_res));
  hstc_fmul u_m7 (.clk_i(clk_i), .en_i(en), .a_i(m6_res), .b_i(rh_q[T_S1-T_RH-1]),
                  .res_o(m7_res));

  hstc_fdiv u_xx (.clk_i(clk_i), .en_i(en), .a_i(s_q[T_DEN-T_S-1]), .b_i(den),
                  .res_o(xx));
  hstc_fdiv u_xy (.clk_i(clk_i), .en_i(en), .a_i(m7_q[hstc_pkg::LAT_ADD-1]), .b_i(den),
                  .res_o(xy));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < T_OUT; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid;
      for (int i = 1; i < T_OUT; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q[0] <= small_now;
      us_q[0] <= us;
      rh_q[0] <= rh;
      m3_q[0] <= m3_res;
      s_q[0]  <= s_now;
      m7_q[0] <= m7_res;
      for (int i = 1; i < T_OUT; i++)               sm_q[i] <= sm_q[i-1];
      for (int i = 1; i < T_M1; i++)                us_q[i] <= us_q[i-1];
      for (int i = 1; i < T_OUT - T_RH; i++)        rh_q[i] <= rh_q[i-1];
      for (int i = 1; i < T_S - T_M3; i++)          m3_q[i] <= m3_q[i-1];
      for (int i = 1; i < T_OUT - T_S; i++)         s_q[i]  <= s_q[i-1];
      for (int i = 1; i < hstc_pkg::LAT_ADD; i++)   m7_q[i] <= m7_q[i-1];
    end
  end

  // Output register with a one-beat skid register behind it.
  logic [hstc_pkg::OUT_W-1:0] pipe_data, out_data_q, skid_data_q;
  logic                       pipe_user, out_user_q, skid_user_q, out_valid_q, take;

  assign pipe_data = {xy, xx, rh_q[T_OUT-T_RH-1], s_q[T_OUT-T_S-1]};
  assign pipe_user = sm_q[T_OUT-1];
  assign take      = en && v_q[T_OUT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) skid_valid_q <= 1'b0;
    end else if (take) begin
      if (!out_valid_q || m_axis_tready) out_valid_q  <= 1'b1;
      else                               skid_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (take) begin
      if (!out_valid_q || m_axis_tready) begin
        out_data_q <= pipe_data;
        out_user_q <= pipe_user;
      end else begin
        skid_data_q <= pipe_data;
        skid_user_q <= pipe_user;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;
endmodule
`default_nettype wire

// File: design/hstc_checker.sv
// Port-level checker for the conductivity tensor block and its bind.
`default_nettype none
`include "hall_signals_to_conductivity_tensor_macros.svh"
module hstc_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tready,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [hstc_pkg::OUT_W-1:0]         m_axis_tdata,
  input wire [0:0]                         m_axis_tuser
);
  // A stalled output beat stays offered and its tdata stays unchanged.
  `HSTC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `HSTC_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // A small-signal beat reports a conductivity of positive zero.
  `HSTC_ASSERT_IMP(a_small_zero, m_axis_tvalid && m_axis_tuser[0],
                   m_axis_tdata[31:0] == 32'd0)
  // The input side only pushes back after the output side has stalled.
  `HSTC_ASSERT_IMP(a_backpressure, !s_axis_tready,
                   $past(m_axis_tvalid && !m_axis_tready))
endmodule

bind hall_signals_to_conductivity_tensor hstc_checker u_hstc_checker (.*);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the Hall-signal to conductivity-tensor pipeline.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hstc_pkg::*;

  // Register index that the block must ignore.
  localparam logic [CFG_IDXW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_WAIT = 60;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned NUM_PHASES = 9;
  localparam logic [31:0] FP_INF = 32'h7F80_0000;
  localparam logic [31:0] FP_SIGN = 32'h8000_0000;
  localparam logic [31:0] DEF_NAN = 32'hFFC0_0000;

  typedef struct packed {
    logic [31:0] cond;
    logic [31:0] hall;
    logic [31:0] xx;
    logic [31:0] xy;
    logic        low_sig;
  } tensor_beat_t;

  typedef struct {
    logic [31:0]  us;
    logic [31:0]  uy;
    bit           typed;
    tensor_beat_t want;
  } sample_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDXW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  hall_signals_to_conductivity_tensor u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the three registers, updated as each write beat lands.
  logic [31:0] ratio_q = FP_ONE;
  logic [31:0] thick_q = FP_ONE;
  logic [31:0] current_q = FP_ONE;

  tensor_beat_t tensor_q[$];
  sample_row_t rows[$];
  int unsigned n_err = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  // ---------------------------------------------------------------------
  // Binary32 arithmetic. Finite non-zero operands go through binary64, which
  // is wide enough that one rounding to binary32 afterwards is exact. Special
  // operands settle on the bit patterns, NaNs x86-style but for 0/0 and NaN/0.
  // ---------------------------------------------------------------------
  function automatic bit f_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic bit f_inf(logic [31:0] x);
    return x[30:0] == FP_INF[30:0];
  endfunction

  function automatic bit f_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic real f_to_real(logic [31:0] x);
    real r;
    if (x[30:23] == 8'd0) begin
      r = real'(x[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return x[31] ? -r : r;
    end
    return $bitstoreal({x[31], 11'(x[30:23]) + 11'd896, x[22:0], 29'd0});
  endfunction

  // Round a binary64 value to nearest-even binary32, subnormals included.
  function automatic logic [31:0] real_to_f(real d);
    logic [63:0] db, sig, q, rem, half;
    logic [31:0] base, res;
    int ue, sh;
    db = $realtobits(d);
    if (db[62:52] == 11'd0) return {db[63], 31'd0};
    ue = int'(db[62:52]) - 1023;
    if (ue > 127) return {db[63], FP_INF[30:0]};
    sig = {11'd0, 1'b1, db[51:0]};
    if (ue >= -126) begin
      sh = 29;
      base = 32'(ue + 126) << 23;
    end else begin
      sh = -97 - ue;
      base = 32'd0;
    end
    if (sh > 60) begin
      q = 64'd0;
    end else begin
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    res = base + q[31:0];
    if (res >= FP_INF) res = FP_INF;
    return {db[63], res[30:0]};
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (f_nan(a)) return a | QUIET_BIT;
    if (f_nan(b)) return b | QUIET_BIT;
    if ((f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) return DEF_NAN;
    if (f_inf(a) || f_inf(b)) return {sgn, FP_INF[30:0]};
    if (f_zero(a) || f_zero(b)) return {sgn, 31'd0};
    return real_to_f(f_to_real(a) * f_to_real(b));
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    // A zero divisor is decided before any NaN is looked at.
    if (f_zero(b)) begin
      if (f_nan(a) || f_zero(a)) return QNAN_POS;
      return {sgn, FP_INF[30:0]};
    end
    if (f_nan(a)) return a | QUIET_BIT;
    if (f_nan(b)) return b | QUIET_BIT;
    if (f_inf(a) && f_inf(b)) return DEF_NAN;
    if (f_inf(a)) return {sgn, FP_INF[30:0]};
    if (f_inf(b) || f_zero(a)) return {sgn, 31'd0};
    return real_to_f(f_to_real(a) / f_to_real(b));
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    real d;
    if (f_nan(a)) return a | QUIET_BIT;
    if (f_nan(b)) return b | QUIET_BIT;
    if (f_inf(a) && f_inf(b) && (a[31] != b[31])) return DEF_NAN;
    if (f_inf(a)) return a;
    if (f_inf(b)) return b;
    if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
    if (f_zero(a)) return b;
    if (f_zero(b)) return a;
    d = f_to_real(a) + f_to_real(b);
    if (d == 0.0) return 32'd0;
    return real_to_f(d);
  endfunction

  // Expected output beat for one sample pair under the current registers.
  function automatic tensor_beat_t invert_hall(logic [31:0] us, logic [31:0] uy);
    tensor_beat_t o;
    logic [31:0] s, rh, den, t;
    o.low_sig = !(us[30:23] == 8'hFF) && (f_to_real({1'b0, us[30:0]}) < 1e-11);
    if (o.low_sig) begin
      s = 32'd0;
    end else begin
      s = f_div(f_mul(f_div(ratio_q, thick_q), current_q), us);
    end
    rh = f_div(f_mul(thick_q, uy), current_q);
    t = f_mul(f_mul(f_mul(rh, rh), s), s);
    den = f_add(t, FP_ONE);
    o.cond = s;
    o.hall = rh;
    o.xx = f_div(s, den);
    o.xy = f_div(f_mul(f_mul(s, s), rh), den);
    return o;
  endfunction

  // Plausible lab magnitudes half of the time, with raw patterns, specials
  // and values straddling the small-signal threshold mixed in.
  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v[30:23] = 8'($urandom_range(100, 150));
      5: ;
      6: v[30:23] = 8'($urandom_range(86, 93));
      7: v[30:0] = {8'd0, v[22:0]};
      8: v[30:0] = {8'hFF, ($urandom_range(0, 1) ? 23'd0 : v[22:0])};
      default: v[30:0] = ($urandom_range(0, 1)) ? 31'd0 : 31'h7F7F_FFFF;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_reg(int unsigned kind);
    logic [31:0] v;
    v = $urandom();
    v[31] = 1'b0;
    case (kind)
      0: v[30:23] = 8'($urandom_range(120, 135));
      1: v[30:23] = 8'($urandom_range(100, 110));
      default: v[30:23] = 8'($urandom_range(112, 125));
    endcase
    return v;
  endfunction

  task automatic add_row(logic [31:0] us, logic [31:0] uy, bit typed = 1'b0,
                         tensor_beat_t want = '0);
    sample_row_t r;
    r.us = us;
    r.uy = uy;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endtask

  // Offer one sample beat and hold it until the block takes it.
  task automatic send_sample(logic [31:0] us, logic [31:0] uy, bit typed,
                             tensor_beat_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {uy, us};
    do @(posedge clk_i); while (!s_axis_tready);
    tensor_q = {tensor_q, (typed ? want : invert_hall(us, uy))};
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tensor_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDXW-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_RATIO:   ratio_q = val;
      REG_THICK:   thick_q = val;
      REG_CURRENT: current_q = val;
      default: ;
    endcase
  endtask

  // Receiver: random short stalls, or one long hold-off on request so the
  // pipeline and its skid register fill and the input side backs up.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Output checker: each accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    tensor_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tuser[0]};
      if (tensor_q.size() == 0) begin
        $display("%0t: unexpected output beat %h", $realtime, got);
        n_err++;
      end else begin
        want = tensor_q.pop_front();
        if (got.cond !== want.cond) begin
          $display("%0t: conductivity expected %h actual %h", $realtime, want.cond, got.cond);
          n_err++;
        end
        if (got.hall !== want.hall) begin
          $display("%0t: hall coeff expected %h actual %h", $realtime, want.hall, got.hall);
          n_err++;
        end
        if (got.xx !== want.xx) begin
          $display("%0t: tensor_xx expected %h actual %h", $realtime, want.xx, got.xx);
          n_err++;
        end
        if (got.xy !== want.xy) begin
          $display("%0t: tensor_xy expected %h actual %h", $realtime, want.xy, got.xy);
          n_err++;
        end
        if (got.low_sig !== want.low_sig) begin
          $display("%0t: small flag expected %b actual %b", $realtime, want.low_sig,
                   got.low_sig);
          n_err++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat on any channel.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Directed rows under the reset registers (all 1.0).
    add_row(FP_ONE, 32'd0, 1'b1, {FP_ONE, 32'd0, FP_ONE, 32'd0, 1'b0});
    add_row(32'd0, 32'd0, 1'b1, {32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
    add_row(FP_SIGN, 32'd0, 1'b1, {32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
    add_row(32'd0, FP_ONE, 1'b1, {32'd0, FP_ONE, 32'd0, 32'd0, 1'b1});
    add_row(32'h2D2F_EC00, FP_ONE);            // first value at the threshold
    add_row(32'hAD2F_EBFF, FP_ONE);            // just below it, negative
    add_row(32'h0000_0001, 32'h8000_0001);     // smallest subnormals
    add_row(32'h7F7F_FFFF, 32'h7F7F_FFFF);     // largest finite
    add_row(32'hFF7F_FFFF, 32'hFF7F_FFFF);
    add_row(FP_INF, FP_ONE);
    add_row(32'hFF80_0000, FP_INF);
    add_row(32'h7FC0_0001, 32'h3F00_0000);     // NaN voltage is not small
    add_row(32'hFF80_0001, 32'hFFFF_FFFF);     // signalling and quiet NaN
    add_row(32'hFFFF_FFFF, 32'd0);
    add_row(32'h3380_0000, 32'h4000_0000);
    add_row(32'hBF80_0000, 32'hC000_0000);
    add_row(32'hAAAA_AAAA, 32'h5555_5555);
    add_row(32'h5555_5555, 32'hAAAA_AAAA);
    foreach (rows[i]) send_sample(rows[i].us, rows[i].uy, rows[i].typed, rows[i].want);
    wait_quiet();

    // Register writes, including the ignored index, then a few checks that
    // a zero thickness divides as IEEE prescribes.
    write_reg(REG_UNUSED, 32'd0);
    write_reg(REG_THICK, 32'd0);
    send_sample(FP_ONE, FP_ONE, 1'b0, '0);
    send_sample(32'd0, FP_INF, 1'b0, '0);
    wait_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      idle_on = (p != NUM_PHASES - 1);
      case (p)
        1: begin
          write_reg(REG_RATIO, pick_reg(0));
          write_reg(REG_THICK, 32'd0);
          write_reg(REG_CURRENT, pick_reg(2));
        end
        2: begin
          write_reg(REG_RATIO, pick_reg(0));
          write_reg(REG_THICK, pick_reg(1));
          write_reg(REG_CURRENT, 32'h8000_0000);
        end
        3: begin
          write_reg(REG_RATIO, 32'h7F7F_FFFF);
          write_reg(REG_THICK, 32'h0000_0001);
          write_reg(REG_CURRENT, 32'hFF7F_FFFF);
        end
        4: begin
          write_reg(REG_RATIO, FP_INF);
          write_reg(REG_THICK, 32'h7FA0_0000);
          write_reg(REG_CURRENT, 32'hFFFF_FFFF);
        end
        5: begin
          write_reg(REG_RATIO, $urandom());
          write_reg(REG_THICK, $urandom());
          write_reg(REG_CURRENT, $urandom());
        end
        6: begin
          write_reg(REG_RATIO, 32'd0);
          write_reg(REG_THICK, 32'h0000_0000);
          write_reg(REG_CURRENT, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_RATIO, pick_reg(0));
          write_reg(REG_THICK, pick_reg(1));
          write_reg(REG_CURRENT, pick_reg(2));
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == 20) hold_req = 1'b1;
        send_sample(pick_float(), pick_float(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tensor_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_err == 0 && tensor_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+design
design/hstc_pkg.sv
design/hstc_round.sv
design/hstc_fmul.sv
design/hstc_fdiv.sv
design/hstc_fadd.sv
design/hall_signals_to_conductivity_tensor.sv
design/hstc_checker.sv
tb/tb.sv
